### rtl/ppm_pkg.sv
// ----------------------------------------------------------------------------
// ppm_pkg: shared types and constants for the polygon pixel mask
// Default sizes, field widths, request codes and the control word that
// travels down the cell chain with each beat.
// ----------------------------------------------------------------------------
package ppm_pkg;

    // default sizes for the top-level parameters
    localparam int MAX_VERTICES_DEF = 16;
    localparam int COORD_BITS_DEF   = 12;

    // fixed field widths
    localparam int VCOUNT_BITS = 5;
    localparam int INDEX_BITS  = 4;
    localparam int COLOR_BITS  = 8;
    localparam int RGB_BITS    = 3 * COLOR_BITS;

    // request codes
    localparam logic REQ_VERTEX = 1'b0;
    localparam logic REQ_PIXEL  = 1'b1;

    // control word handed from cell to cell
    typedef struct packed {
        logic valid;     // stage holds a beat
        logic is_pixel;  // pixel beat, else vertex load
        logic odd;       // running crossing parity
    } ctrl_t;

endpackage

### rtl/ppm_cell.sv
// ----------------------------------------------------------------------------
// ppm_cell: one edge cell of the polygon mask chain
// Keeps copies of its own vertex, the next vertex and vertex zero, updated by
// vertex loads as they pass. A pixel beat gets its parity flipped when the
// edge from this vertex to the next crosses the pixel row left of the pixel.
// ----------------------------------------------------------------------------
module ppm_cell
    import ppm_pkg::*;
#(
    parameter int CELL_IDX     = 0,
    parameter int COORD_BITS   = COORD_BITS_DEF,
    parameter int CW           = VCOUNT_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic [CW-1:0]         n_active,
    input  ctrl_t                 ctrl_in,
    input  logic [INDEX_BITS-1:0] index_in,
    input  logic [COORD_BITS-1:0] x_in,
    input  logic [COORD_BITS-1:0] y_in,
    input  logic [RGB_BITS-1:0]   rgb_in,
    output ctrl_t                 ctrl_out,
    output logic [INDEX_BITS-1:0] index_out,
    output logic [COORD_BITS-1:0] x_out,
    output logic [COORD_BITS-1:0] y_out,
    output logic [RGB_BITS-1:0]   rgb_out
);

    localparam int C  = COORD_BITS;
    localparam int PW = 2 * C + 2;

    // vertex copies (undefined until loaded)
    logic [C-1:0] a_x_reg, a_y_reg;   // vertex CELL_IDX
    logic [C-1:0] b_x_reg, b_y_reg;   // vertex CELL_IDX+1
    logic [C-1:0] z_x_reg, z_y_reg;   // vertex 0

    // stage registers
    ctrl_t                 ctrl_reg, ctrl_next;
    logic [INDEX_BITS-1:0] index_reg;
    logic [C-1:0]          x_reg, y_reg;
    logic [RGB_BITS-1:0]   rgb_reg;

    // edge test signals
    logic                active, last, load, hit, in_range;
    logic [C-1:0]        e_x, e_y, lo_x, lo_y, hi_x, hi_y;
    logic signed [C:0]   dx, dy, dpx, dpy;
    logic signed [PW-1:0] lhs, rhs;

    assign load   = ctrl_in.valid && (ctrl_in.is_pixel == REQ_VERTEX);
    assign active = CW'(CELL_IDX) < n_active;
    assign last   = CW'(CELL_IDX + 1) == n_active;

    // edge endpoints ordered by y, then exact crossing compare
    always_comb
    begin
        e_x = last ? z_x_reg : b_x_reg;
        e_y = last ? z_y_reg : b_y_reg;
        if (a_y_reg > e_y)
        begin
            lo_x = e_x;     lo_y = e_y;
            hi_x = a_x_reg; hi_y = a_y_reg;
        end
        else
        begin
            lo_x = a_x_reg; lo_y = a_y_reg;
            hi_x = e_x;     hi_y = e_y;
        end
        in_range = (lo_y <= y_in) && (y_in < hi_y);
        dx  = $signed({1'b0, hi_x}) - $signed({1'b0, lo_x});
        dy  = $signed({1'b0, hi_y - lo_y});
        dpy = $signed({1'b0, y_in - lo_y});
        dpx = $signed({1'b0, x_in}) - $signed({1'b0, lo_x});
        lhs = PW'(dx) * PW'(dpy);
        rhs = PW'(dpx) * PW'(dy);
        hit = ctrl_in.valid && ctrl_in.is_pixel && active && in_range && (lhs < rhs);

        ctrl_next     = ctrl_in;
        ctrl_next.odd = ctrl_in.odd ^ hit;
    end

    // vertex copies follow loads in stream order
    always_ff @(posedge clk)
    begin
        if (en && load)
        begin
            if (32'(index_in) == CELL_IDX)
            begin
                a_x_reg <= x_in;
                a_y_reg <= y_in;
            end
            if (32'(index_in) == CELL_IDX + 1)
            begin
                b_x_reg <= x_in;
                b_y_reg <= y_in;
            end
            if (index_in == '0)
            begin
                z_x_reg <= x_in;
                z_y_reg <= y_in;
            end
        end
    end

    // control stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (en)
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    // payload stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            index_reg <= index_in;
            x_reg     <= x_in;
            y_reg     <= y_in;
            rgb_reg   <= rgb_in;
        end
    end

    assign ctrl_out  = ctrl_reg;
    assign index_out = index_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign rgb_out   = rgb_reg;

endmodule

### rtl/polygon_pixel_mask.sv
// ----------------------------------------------------------------------------
// polygon_pixel_mask: even-odd polygon mask on a pixel stream
// Vertex loads and pixels share one input channel; pixels inside the polygon
// (all pixels while the vertex count is zero) pass, the others come out black with outside set.
// ----------------------------------------------------------------------------
// Every beat runs down a chain of MAX_VERTICES edge cells, one cell per
// polygon edge, and then through one output register; a new beat, vertex or
// pixel, is taken every cycle in which the chain advances, as set out below.
// Vertex loads travel the same chain and update each cell's copy as they pass,
// so loads and pixels take effect in stream order with no draining. The chain
// advances whenever the output register is empty or being taken; a stalled
// result holds the whole chain.
// vertex_count is to be written only while no beat is in flight.
module polygon_pixel_mask
    import ppm_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration
    input  logic                   cfg_wr_en,
    input  logic [VCOUNT_BITS-1:0] cfg_wr_data,
    // input channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   req_type,
    input  logic [INDEX_BITS-1:0]  vertex_index,
    input  logic [COORD_BITS-1:0]  vertex_x,
    input  logic [COORD_BITS-1:0]  vertex_y,
    input  logic [COORD_BITS-1:0]  pixel_x,
    input  logic [COORD_BITS-1:0]  pixel_y,
    input  logic [COLOR_BITS-1:0]  red_in,
    input  logic [COLOR_BITS-1:0]  green_in,
    input  logic [COLOR_BITS-1:0]  blue_in,
    // output channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [COLOR_BITS-1:0]  red_out,
    output logic [COLOR_BITS-1:0]  green_out,
    output logic [COLOR_BITS-1:0]  blue_out,
    output logic                   outside
);

    localparam int CNT_BITS = $clog2(MAX_VERTICES + 1);
    localparam int CW = (CNT_BITS > VCOUNT_BITS) ? CNT_BITS : VCOUNT_BITS;

    // configuration register
    logic [VCOUNT_BITS-1:0] vertex_count_reg;
    logic [CW-1:0]          cnt_ext, n_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            vertex_count_reg <= cfg_wr_data;
        end
    end

    // count saturated to the table size
    assign cnt_ext = CW'(vertex_count_reg);
    assign n_sat   = (cnt_ext > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : cnt_ext;

    // chain advance
    logic  out_valid_reg;
    logic  en;
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // chain taps, tap 0 is the input beat
    ctrl_t                  ch_ctrl  [0:MAX_VERTICES];
    logic [INDEX_BITS-1:0]  ch_index [0:MAX_VERTICES];
    logic [COORD_BITS-1:0]  ch_x     [0:MAX_VERTICES];
    logic [COORD_BITS-1:0]  ch_y     [0:MAX_VERTICES];
    logic [RGB_BITS-1:0]    ch_rgb   [0:MAX_VERTICES];

    // vertex and pixel share the coordinate lanes
    always_comb
    begin
        ch_ctrl[0].valid    = in_valid;
        ch_ctrl[0].is_pixel = req_type;
        ch_ctrl[0].odd      = 1'b0;
        ch_index[0]         = vertex_index;
        ch_x[0]             = (req_type == REQ_PIXEL) ? pixel_x : vertex_x;
        ch_y[0]             = (req_type == REQ_PIXEL) ? pixel_y : vertex_y;
        ch_rgb[0]           = {red_in, green_in, blue_in};
    end

    // edge cells
    for (genvar k = 0; k < MAX_VERTICES; k++)
    begin : g_cell
        ppm_cell #(
            .CELL_IDX     (k),
            .COORD_BITS   (COORD_BITS),
            .CW           (CW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .n_active  (n_sat),
            .ctrl_in   (ch_ctrl[k]),
            .index_in  (ch_index[k]),
            .x_in      (ch_x[k]),
            .y_in      (ch_y[k]),
            .rgb_in    (ch_rgb[k]),
            .ctrl_out  (ch_ctrl[k+1]),
            .index_out (ch_index[k+1]),
            .x_out     (ch_x[k+1]),
            .y_out     (ch_y[k+1]),
            .rgb_out   (ch_rgb[k+1])
        );
    end

    // output register: pixel beats only
    ctrl_t                 tail;
    logic                  outside_next;
    logic                  outside_reg;
    logic [RGB_BITS-1:0]   rgb_next, rgb_reg;

    always_comb
    begin
        tail         = ch_ctrl[MAX_VERTICES];
        outside_next = (n_sat != '0) && !tail.odd;
        rgb_next     = outside_next ? '0 : ch_rgb[MAX_VERTICES];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= tail.valid && (tail.is_pixel == REQ_PIXEL);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            outside_reg <= outside_next;
            rgb_reg     <= rgb_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = rgb_reg[3*COLOR_BITS-1:2*COLOR_BITS];
    assign green_out = rgb_reg[2*COLOR_BITS-1:COLOR_BITS];
    assign blue_out  = rgb_reg[COLOR_BITS-1:0];
    assign outside   = outside_reg;

endmodule
